### hw/rtl/pss_pkg.sv
// Shared types and constants for the positional sequence store.
// Holds action, status and sequencer state encodings and stream field widths.
// No dependencies.
package pss_pkg;

  localparam int POS_W       = 9;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SHIFT,
    S_DRAIN,
    S_FILL,
    S_RESP
  } state_t;

endpackage

### hw/rtl/positional_sequence_store.sv
// Positional sequence store: insert, overwrite, delete and read by 1-based position.
// Each input beat is carried through to its result before another is taken. A middle insert,
// or a delete before the last element, shifts the elements behind the position, one element
// per cycle through the memory's separate read and write ports. The result register frees
// the input side early.
// Reset clears the element count and handshake state; memory contents are not cleared.
module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // action[1:0], position[10:2], value[42:11]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status[1:0], length[10:2],
                                             // read_value[42:11], placed_at[51:43]
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = (CW > POS_W) ? CW : POS_W;
  localparam int EXT_W = 64;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  act_t                    act_r, act_nxt;
  logic [VALUE_WIDTH-1:0]  val_r, val_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [AW-1:0]           end_r, end_nxt;
  logic [AW-1:0]           wb_addr_r, wb_addr_nxt;
  logic                    wb_v_r, wb_v_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [POS_W-1:0]        res_placed_r, res_placed_nxt;
  logic [DATA_W-1:0]       res_rd_r, res_rd_nxt;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] mem_q_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [AW-1:0]          mem_ra;
  logic [VALUE_WIDTH-1:0] mem_wd;

  act_t                       in_action;
  logic [POS_W-1:0]           in_position;
  logic signed [DATA_W-1:0]   in_value;
  logic signed [EXT_W-1:0]    val_ext;
  logic [VALUE_WIDTH-1:0]     val_st;
  logic signed [VALUE_WIDTH-1:0] mem_q_s;
  logic signed [EXT_W-1:0]    rd_ext;
  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext;
  logic [AW-1:0]              pos_m1;
  logic                       cnt_zero;
  logic                       pos_zero;
  logic                       cnt_full;
  logic                       pos_in;
  logic                       mid_ins;
  logic                       acc_ok;

  assign in_action   = act_t'(in_tdata[1:0]);
  assign in_position = in_tdata[10:2];
  assign in_value    = in_tdata[42:11];

  assign val_ext  = EXT_W'(in_value);
  assign val_st   = val_ext[VALUE_WIDTH-1:0];
  assign mem_q_s  = mem_q_r;
  assign rd_ext   = EXT_W'(mem_q_s);

  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);
  assign pos_m1   = AW'(pos_ext - PW'(1));
  assign cnt_zero = (count_r == '0);
  assign pos_zero = (in_position == '0);
  assign cnt_full = (cnt_ext >= PW'(CAPACITY));
  assign pos_in   = !pos_zero && (pos_ext <= cnt_ext);
  assign mid_ins  = !cnt_zero && pos_in && !cnt_full;
  assign acc_ok   = !cnt_zero && pos_in;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_action)
            ACT_INSERT: state_nxt = mid_ins ? S_SHIFT : S_RESP;
            ACT_READ:   state_nxt = acc_ok ? S_RDWAIT : S_RESP;
            ACT_DELETE: state_nxt = (acc_ok && pos_ext != cnt_ext) ? S_SHIFT : S_RESP;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_RDWAIT: state_nxt = S_RESP;
      S_SHIFT: begin
        if (src_r == end_r) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = (act_r == ACT_INSERT) ? S_FILL : S_RESP;
      S_FILL:   state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    src_nxt        = src_r;
    end_nxt        = end_r;
    wb_addr_nxt    = wb_addr_r;
    wb_v_nxt       = wb_v_r;
    res_status_nxt = res_status_r;
    res_placed_nxt = res_placed_r;
    res_rd_nxt     = res_rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = wb_addr_r;
    mem_wd         = mem_q_r;
    mem_ra         = src_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt        = in_action;
          val_nxt        = val_st;
          wb_v_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_placed_nxt = '0;
          res_rd_nxt     = '0;
          case (in_action)
            ACT_INSERT: begin
              if (cnt_zero) begin
                mem_we         = 1'b1;
                mem_wa         = '0;
                mem_wd         = val_st;
                count_nxt      = CW'(1);
                res_placed_nxt = POS_W'(1);
              end else if (pos_zero) begin
                res_status_nxt = ST_RANGE;
              end else if (cnt_full) begin
                res_status_nxt = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                mem_we         = 1'b1;
                mem_wa         = AW'(count_r);
                mem_wd         = val_st;
                count_nxt      = CW'(count_r + CW'(1));
                res_placed_nxt = POS_W'(cnt_ext + PW'(1));
              end else begin
                src_nxt        = AW'(count_r - CW'(1));
                end_nxt        = pos_m1;
                count_nxt      = CW'(count_r + CW'(1));
                res_placed_nxt = in_position;
              end
            end
            default: begin
              if (cnt_zero) begin
                res_status_nxt = ST_EMPTY;
              end else if (!pos_in) begin
                res_status_nxt = ST_RANGE;
              end else begin
                res_placed_nxt = in_position;
                case (in_action)
                  ACT_WRITE: begin
                    mem_we = 1'b1;
                    mem_wa = pos_m1;
                    mem_wd = val_st;
                  end
                  ACT_DELETE: begin
                    count_nxt = CW'(count_r - CW'(1));
                    src_nxt   = AW'(pos_ext);
                    end_nxt   = AW'(count_r - CW'(1));
                  end
                  default: mem_ra = pos_m1;
                endcase
              end
            end
          endcase
        end
      end
      S_RDWAIT: res_rd_nxt = rd_ext[DATA_W-1:0];
      S_SHIFT: begin
        mem_ra   = src_r;
        mem_we   = wb_v_r;
        wb_v_nxt = 1'b1;
        if (act_r == ACT_INSERT) begin
          wb_addr_nxt = src_r + AW'(1);
          src_nxt     = src_r - AW'(1);
        end else begin
          wb_addr_nxt = src_r - AW'(1);
          src_nxt     = src_r + AW'(1);
        end
      end
      S_DRAIN: mem_we = 1'b1;
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = end_r;
        mem_wd = val_r;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, res_placed_r, res_rd_r, POS_W'(count_r), res_status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wb_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      wb_v_r      <= wb_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    src_r        <= src_nxt;
    end_r        <= end_nxt;
    wb_addr_r    <= wb_addr_nxt;
    res_status_r <= res_status_nxt;
    res_placed_r <= res_placed_nxt;
    res_rd_r     <= res_rd_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

### hw/rtl/pss_checker.sv
// Port-level checks for the positional sequence store, attached by bind.
// Depends on pss_pkg and the top level positional_sequence_store.
module pss_checker
  import pss_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,   // action[1:0], position[10:2], value[42:11]
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata   // status[1:0], length[10:2],
                                            // read_value[42:11], placed_at[51:43]
);

  status_t          status;
  logic [POS_W-1:0] length;
  logic [DATA_W-1:0] read_value;
  logic [POS_W-1:0] placed_at;
  logic             in_beat;

  assign status     = status_t'(out_tdata[1:0]);
  assign length     = out_tdata[10:2];
  assign read_value = out_tdata[42:11];
  assign placed_at  = out_tdata[51:43];
  assign in_beat    = in_tvalid && in_tready && (in_tdata[1:0] == ACT_READ);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((status == ST_OK) == (placed_at != '0)))
    else $error("placed_at disagrees with status");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != ST_OK |-> read_value == '0)
    else $error("read_value nonzero on error");

  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(length) <= CAPACITY) &&
                   (status != ST_EMPTY || length == '0) &&
                   (status != ST_FULL || int'(length) == CAPACITY))
    else $error("length inconsistent with capacity or status");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input taken again before a read completed");

endmodule

bind positional_sequence_store pss_checker #(.CAPACITY(CAPACITY)) u_pss_checker (.*);
